[design/lcdn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcdn_pkg;

    localparam int MAX_DIGITS  = 4;
    localparam int VALUE_W     = 16;
    localparam int UNITS_W     = 8;
    localparam int WAITS_W     = 3;
    localparam int BCD_ITER_W  = $clog2(VALUE_W);
    localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PC_W        = 5;
    localparam int CNT_W       = 3;

    localparam logic [3:0] INIT_NIBBLE  = 4'b0010;
    localparam logic [7:0] FUNCTION_SET = 8'b0010_0011;
    localparam logic [7:0] DISPLAY_ON   = 8'b0000_1100;
    localparam logic [7:0] ENTRY_MODE   = 8'b0000_0110;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    localparam logic [UNITS_W-1:0] NIBBLE_HIGH_RESET = 8'd8;
    localparam logic [UNITS_W-1:0] NIBBLE_LOW_RESET  = 8'd2;
    localparam logic [UNITS_W-1:0] WAIT_HIGH_RESET   = 8'd2;
    localparam logic [UNITS_W-1:0] WAIT_LOW_RESET    = 8'd2;
    localparam logic [WAITS_W-1:0] WAITS_RESET       = 3'd2;
    localparam logic [CNT_W-1:0]   WAITS_MAX         = 3'd4;
    localparam logic [CNT_W-1:0]   INIT_WAITS        = 3'd2;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_INIT  = 5'd0;
    localparam pc_t PC_INSTR = 5'd15;
    localparam pc_t PC_CHAR  = 5'd18;
    localparam pc_t PC_NUM   = 5'd20;
    localparam pc_t PC_DIGIT = 5'd21;
    localparam pc_t PC_LAST  = 5'd22;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_INSTR = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NUM   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_NIBBLE_HIGH = 3'd0,
        REG_NIBBLE_LOW  = 3'd1,
        REG_WAIT_HIGH   = 3'd2,
        REG_WAIT_LOW    = 3'd3,
        REG_WAITS       = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SRC_CONST   = 2'd0,
        SRC_BYTE_HI = 2'd1,
        SRC_BYTE_LO = 2'd2,
        SRC_DIGIT   = 2'd3
    } src_t;

    typedef enum logic [2:0] {
        SEQ_NEXT        = 3'd0,
        SEQ_END         = 3'd1,
        SEQ_END_IF_ZERO = 3'd2,
        SEQ_REPEAT      = 3'd3,
        SEQ_JUMP_BACK   = 3'd4
    } seq_t;

    typedef struct packed {
        logic       emit;
        src_t       src;
        logic [3:0] konst;
        logic       rs;
        logic       released;
        seq_t       seq;
        pc_t        target;
    } ucode_t;

    function automatic ucode_t nib_word(input logic [3:0] k, input seq_t s);
        ucode_t w;
        w = '{emit: 1'b1, src: SRC_CONST, konst: k, rs: 1'b0, released: 1'b0,
              seq: s, target: PC_INIT};
        return w;
    endfunction

    function automatic ucode_t byte_word(input src_t src, input logic rs, input seq_t s);
        ucode_t w;
        w = '{emit: 1'b1, src: src, konst: 4'h0, rs: rs, released: 1'b0,
              seq: s, target: PC_INIT};
        return w;
    endfunction

    function automatic ucode_t wait_word(input seq_t s);
        ucode_t w;
        w = '{emit: 1'b1, src: SRC_CONST, konst: 4'h0, rs: 1'b0, released: 1'b1,
              seq: s, target: PC_INIT};
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            5'd0:  w = nib_word(INIT_NIBBLE, SEQ_NEXT);
            5'd1:  w = wait_word(SEQ_NEXT);
            5'd2:  w = wait_word(SEQ_NEXT);
            5'd3:  w = nib_word(FUNCTION_SET[7:4], SEQ_NEXT);
            5'd4:  w = nib_word(FUNCTION_SET[3:0], SEQ_NEXT);
            5'd5:  w = wait_word(SEQ_NEXT);
            5'd6:  w = wait_word(SEQ_NEXT);
            5'd7:  w = nib_word(DISPLAY_ON[7:4], SEQ_NEXT);
            5'd8:  w = nib_word(DISPLAY_ON[3:0], SEQ_NEXT);
            5'd9:  w = wait_word(SEQ_NEXT);
            5'd10: w = wait_word(SEQ_NEXT);
            5'd11: w = nib_word(ENTRY_MODE[7:4], SEQ_NEXT);
            5'd12: w = nib_word(ENTRY_MODE[3:0], SEQ_NEXT);
            5'd13: w = wait_word(SEQ_NEXT);
            5'd14: w = wait_word(SEQ_END);
            5'd15: w = byte_word(SRC_BYTE_HI, 1'b0, SEQ_NEXT);
            5'd16: w = byte_word(SRC_BYTE_LO, 1'b0, SEQ_END_IF_ZERO);
            5'd17: w = wait_word(SEQ_REPEAT);
            5'd18: w = byte_word(SRC_BYTE_HI, 1'b1, SEQ_NEXT);
            5'd19: w = byte_word(SRC_BYTE_LO, 1'b1, SEQ_END);
            5'd20: begin
                w = byte_word(SRC_CONST, 1'b1, SEQ_NEXT);
                w.emit = 1'b0;
            end
            5'd21: begin
                w = byte_word(SRC_CONST, 1'b1, SEQ_NEXT);
                w.konst = CHAR_ZERO[7:4];
            end
            5'd22: begin
                w = byte_word(SRC_DIGIT, 1'b1, SEQ_JUMP_BACK);
                w.target = PC_DIGIT;
            end
            default: w = wait_word(SEQ_END);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/lcdn_bcd.sv]
`timescale 1ns / 1ps
`default_nettype none

module lcdn_bcd
    import lcdn_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [VALUE_W-1:0]           bin,
    output logic                              busy,
    output logic [MAX_DIGITS-1:0][3:0]        digits
);

    logic                              busy_reg, busy_next;
    logic [BCD_ITER_W-1:0]             iter_reg, iter_next;
    logic [VALUE_W-1:0]                bin_reg, bin_next;
    logic [MAX_DIGITS-1:0][3:0]        dig_reg, dig_next;
    logic [MAX_DIGITS-1:0][3:0]        adj;
    logic [4*MAX_DIGITS-1:0]           adj_flat;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
    end

    assign adj_flat = adj;

    always_comb begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        bin_next  = bin_reg;
        dig_next  = dig_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            bin_next  = bin;
            dig_next  = '0;
        end else if (busy_reg) begin
            dig_next  = {adj_flat[4*MAX_DIGITS-2:0], bin_reg[VALUE_W-1]};
            bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == BCD_ITER_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        iter_reg <= iter_next;
        bin_reg  <= bin_next;
        dig_reg  <= dig_next;
    end

    assign busy   = busy_reg;
    assign digits = dig_reg;

endmodule

`default_nettype wire

[design/char_lcd_nibble_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turns requests for a character display on a 4-bit bus into enable pulses.
// A request beat on the s_ channel carries a command, a value and a digit
// count. Each m_ beat is one enable pulse: register select and bus release
// in m_tuser, the nibble and the high and low hold times in m_tdata, and
// m_tlast on the final pulse of the request.
// Pulses come out of a microcode table, one step per cycle unless a step
// waits on a full output register or on the converter. While the receiver
// keeps m_tready high, the request is latched into the program counter, the
// first pulse then goes into the output register and the rest follow one per
// cycle. Init gives 15 pulses, an instruction 2 plus up to 4 busy-wait
// pulses, a character 2, and a number 2 per digit after BCD conversion.
// One request is in work at a time; s_tready returns high at the same edge
// that loads the last pulse into the output register. A stalled receiver
// holds the output register and the sequencer waits on it. Reset empties
// the output register, idles the sequencer and loads the default hold times.
// Registers are to be written over the APB port only while idle; unchecked.
module char_lcd_nibble_sequencer
    import lcdn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // command[1:0], value[17:2], digit_code[19:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // nibble[3:0], high_units[11:4], low_units[19:12]
    output logic [1:0]       m_tuser,   // reg_select[0], bus_released[1]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [UNITS_W-1:0] nib_high_reg, nib_low_reg, wait_high_reg, wait_low_reg;
    logic [WAITS_W-1:0] waits_reg;
    logic               cfg_write;

    logic               busy_reg, busy_next;
    pc_t                pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         byte_reg, byte_next;

    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    cmd_t               in_cmd;
    logic [VALUE_W-1:0] in_value;
    logic [1:0]         in_dcode;
    logic               in_accept;

    ucode_t             uw;
    logic               out_free;
    logic               step_go;
    logic               finish;
    logic [3:0]         nib;
    logic [UNITS_W-1:0] hi_units, lo_units;
    logic [CNT_W-1:0]   waits_sat;
    logic [CNT_W-1:0]   digit_count;
    logic [DIGIT_IDX_W-1:0]          digit_idx;
    logic [CNT_W-1:0]                cnt_minus;
    logic                            bcd_start, bcd_busy;
    logic [MAX_DIGITS-1:0][3:0]      bcd_digits;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nib_high_reg  <= NIBBLE_HIGH_RESET;
            nib_low_reg   <= NIBBLE_LOW_RESET;
            wait_high_reg <= WAIT_HIGH_RESET;
            wait_low_reg  <= WAIT_LOW_RESET;
            waits_reg     <= WAITS_RESET;
        end else if (cfg_write) begin
            case (cfg_idx_t'(paddr[4:2]))
                REG_NIBBLE_HIGH: nib_high_reg  <= pwdata[UNITS_W-1:0];
                REG_NIBBLE_LOW:  nib_low_reg   <= pwdata[UNITS_W-1:0];
                REG_WAIT_HIGH:   wait_high_reg <= pwdata[UNITS_W-1:0];
                REG_WAIT_LOW:    wait_low_reg  <= pwdata[UNITS_W-1:0];
                REG_WAITS:       waits_reg     <= pwdata[WAITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx_t'(paddr[4:2]))
            REG_NIBBLE_HIGH: prdata = 32'(nib_high_reg);
            REG_NIBBLE_LOW:  prdata = 32'(nib_low_reg);
            REG_WAIT_HIGH:   prdata = 32'(wait_high_reg);
            REG_WAIT_LOW:    prdata = 32'(wait_low_reg);
            REG_WAITS:       prdata = 32'(waits_reg);
            default:         prdata = '0;
        endcase
    end

    assign in_cmd    = cmd_t'(s_tdata[1:0]);
    assign in_value  = s_tdata[17:2];
    assign in_dcode  = s_tdata[19:18];
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;

    assign waits_sat = (CNT_W'(waits_reg) > WAITS_MAX) ? WAITS_MAX : CNT_W'(waits_reg);

    always_comb begin
        case (in_dcode)
            2'd0:    digit_count = CNT_W'(1);
            2'd1:    digit_count = CNT_W'(2);
            default: digit_count = CNT_W'(MAX_DIGITS);
        endcase
    end

    assign bcd_start = in_accept && (in_cmd == CMD_NUM);

    lcdn_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin     (in_value),
        .busy    (bcd_busy),
        .digits  (bcd_digits)
    );

    assign uw        = ucode_rom(pc_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign step_go   = busy_reg && (uw.emit ? out_free : !bcd_busy);
    assign cnt_minus = cnt_reg - 1'b1;
    assign digit_idx = cnt_minus[DIGIT_IDX_W-1:0];

    always_comb begin
        case (uw.seq)
            SEQ_END:         finish = 1'b1;
            SEQ_END_IF_ZERO: finish = (cnt_reg == '0);
            SEQ_REPEAT:      finish = (cnt_reg == CNT_W'(1));
            SEQ_JUMP_BACK:   finish = (cnt_reg == CNT_W'(1));
            default:         finish = 1'b0;
        endcase
    end

    always_comb begin
        case (uw.src)
            SRC_BYTE_HI: nib = byte_reg[7:4];
            SRC_BYTE_LO: nib = byte_reg[3:0];
            SRC_DIGIT:   nib = CHAR_ZERO[3:0] + bcd_digits[digit_idx];
            default:     nib = uw.konst;
        endcase
        hi_units = uw.released ? wait_high_reg : nib_high_reg;
        lo_units = uw.released ? wait_low_reg : nib_low_reg;
    end

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        byte_next = byte_reg;
        if (in_accept) begin
            busy_next = 1'b1;
            byte_next = in_value[7:0];
            case (in_cmd)
                CMD_INIT: begin
                    pc_next  = PC_INIT;
                    cnt_next = INIT_WAITS;
                end
                CMD_INSTR: begin
                    pc_next  = PC_INSTR;
                    cnt_next = waits_sat;
                end
                CMD_CHAR: begin
                    pc_next  = PC_CHAR;
                    cnt_next = '0;
                end
                default: begin
                    pc_next  = PC_NUM;
                    cnt_next = digit_count;
                end
            endcase
        end else if (step_go) begin
            if (finish) begin
                busy_next = 1'b0;
            end else begin
                case (uw.seq)
                    SEQ_REPEAT: cnt_next = cnt_minus;
                    SEQ_JUMP_BACK: begin
                        cnt_next = cnt_minus;
                        pc_next  = uw.target;
                    end
                    default: pc_next = pc_reg + 1'b1;
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (step_go && uw.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, lo_units, hi_units, nib};
            m_user_next  = {uw.released, uw.rs};
            m_last_next  = finish;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= PC_INIT;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("sequencer not busy after a request was taken");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_DIGITS) || cnt_reg <= WAITS_MAX)
        else $error("step counter out of range");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pc_reg <= PC_LAST)
        else $error("program counter beyond the microcode table");

    a_released_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[3:0] == 4'h0 && !m_tuser[0]))
        else $error("busy-wait beat carries data or register select");

endmodule

`default_nettype wire

[dv/tb_char_lcd_nibble_sequencer.sv]
`timescale 1ns / 1ps

import lcdn_pkg::*;

typedef struct {
    logic       reg_select;
    logic [3:0] nibble;
    logic       bus_released;
    logic [7:0] high_units;
    logic [7:0] low_units;
    logic       last;
} lcd_pulse_t;

class lcd_pulse_board;
    logic [UNITS_W-1:0] nib_high;
    logic [UNITS_W-1:0] nib_low;
    logic [UNITS_W-1:0] wait_high;
    logic [UNITS_W-1:0] wait_low;
    logic [WAITS_W-1:0] instr_waits;
    lcd_pulse_t         pending_pulses[$];
    int                 mismatches;
    int                 pulses_seen;

    function new();
        nib_high    = NIBBLE_HIGH_RESET;
        nib_low     = NIBBLE_LOW_RESET;
        wait_high   = WAIT_HIGH_RESET;
        wait_low    = WAIT_LOW_RESET;
        instr_waits = WAITS_RESET;
        mismatches  = 0;
        pulses_seen = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function void write_reg(int idx, logic [31:0] data);
        case (idx)
            REG_NIBBLE_HIGH: nib_high    = data[UNITS_W-1:0];
            REG_NIBBLE_LOW:  nib_low     = data[UNITS_W-1:0];
            REG_WAIT_HIGH:   wait_high   = data[UNITS_W-1:0];
            REG_WAIT_LOW:    wait_low    = data[UNITS_W-1:0];
            REG_WAITS:       instr_waits = data[WAITS_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] reg_value(int idx);
        case (idx)
            REG_NIBBLE_HIGH: return 32'(nib_high);
            REG_NIBBLE_LOW:  return 32'(nib_low);
            REG_WAIT_HIGH:   return 32'(wait_high);
            REG_WAIT_LOW:    return 32'(wait_low);
            REG_WAITS:       return 32'(instr_waits);
            default:         return 32'h0;
        endcase
    endfunction

    function void push_nibble(logic rs, logic [3:0] nib);
        lcd_pulse_t p;
        p.reg_select   = rs;
        p.nibble       = nib;
        p.bus_released = 1'b0;
        p.high_units   = nib_high;
        p.low_units    = nib_low;
        p.last         = 1'b0;
        pending_pulses.push_back(p);
    endfunction

    function void push_byte(logic rs, logic [7:0] data);
        push_nibble(rs, data[7:4]);
        push_nibble(rs, data[3:0]);
    endfunction

    function void push_waits(int count);
        lcd_pulse_t p;
        p.reg_select   = 1'b0;
        p.nibble       = 4'h0;
        p.bus_released = 1'b1;
        p.high_units   = wait_high;
        p.low_units    = wait_low;
        p.last         = 1'b0;
        for (int i = 0; i < count; i++) begin
            pending_pulses.push_back(p);
        end
    endfunction

    function void note_request(cmd_t cmd, logic [15:0] value, logic [1:0] dcode);
        int unsigned digits;
        int unsigned scale;
        int unsigned waits;
        case (cmd)
            CMD_INIT: begin
                push_nibble(1'b0, INIT_NIBBLE);
                push_waits(INIT_WAITS);
                push_byte(1'b0, FUNCTION_SET);
                push_waits(INIT_WAITS);
                push_byte(1'b0, DISPLAY_ON);
                push_waits(INIT_WAITS);
                push_byte(1'b0, ENTRY_MODE);
                push_waits(INIT_WAITS);
            end
            CMD_INSTR: begin
                waits = (instr_waits > WAITS_MAX) ? WAITS_MAX : instr_waits;
                push_byte(1'b0, value[7:0]);
                push_waits(waits);
            end
            CMD_CHAR: begin
                push_byte(1'b1, value[7:0]);
            end
            default: begin
                digits = (dcode == 2'd0) ? 1 : (dcode == 2'd1) ? 2 : MAX_DIGITS;
                scale  = 1;
                for (int i = 1; i < digits; i++) begin
                    scale *= 10;
                end
                for (int i = 0; i < digits; i++) begin
                    push_byte(1'b1, CHAR_ZERO + 8'((int'(value) / scale) % 10));
                    scale = (scale > 1) ? scale / 10 : 1;
                end
            end
        endcase
        pending_pulses[pending_pulses.size() - 1].last = 1'b1;
    endfunction

    task check_pulse(lcd_pulse_t got);
        lcd_pulse_t want;
        pulses_seen++;
        if (pending_pulses.size() == 0) begin
            report($sformatf("pulse %0d arrived with none expected", pulses_seen));
        end else begin
            want = pending_pulses.pop_front();
            if (got.reg_select !== want.reg_select)
                report($sformatf("pulse %0d reg_select %b, expected %b",
                                 pulses_seen, got.reg_select, want.reg_select));
            if (got.nibble !== want.nibble)
                report($sformatf("pulse %0d nibble %h, expected %h",
                                 pulses_seen, got.nibble, want.nibble));
            if (got.bus_released !== want.bus_released)
                report($sformatf("pulse %0d bus_released %b, expected %b",
                                 pulses_seen, got.bus_released, want.bus_released));
            if (got.high_units !== want.high_units)
                report($sformatf("pulse %0d high_units %0d, expected %0d",
                                 pulses_seen, got.high_units, want.high_units));
            if (got.low_units !== want.low_units)
                report($sformatf("pulse %0d low_units %0d, expected %0d",
                                 pulses_seen, got.low_units, want.low_units));
            if (got.last !== want.last)
                report($sformatf("pulse %0d last %b, expected %b",
                                 pulses_seen, got.last, want.last));
        end
    endtask
endclass

module tb_char_lcd_nibble_sequencer;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 58;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // command[1:0], value[17:2], digit_code[19:18]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // nibble[3:0], high_units[11:4], low_units[19:12]
    logic [1:0]  m_tuser;    // reg_select[0], bus_released[1]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_pulse_board board = new();
    lcd_pulse_t     seen_pulse;
    logic           no_idle;
    int             cycle_count;

    char_lcd_nibble_sequencer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_pulse.reg_select   = m_tuser[0];
            seen_pulse.bus_released = m_tuser[1];
            seen_pulse.nibble       = m_tdata[3:0];
            seen_pulse.high_units   = m_tdata[11:4];
            seen_pulse.low_units    = m_tdata[19:12];
            seen_pulse.last         = m_tlast;
            board.check_pulse(seen_pulse);
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (!no_idle && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_request(cmd_t cmd, logic [15:0] value, logic [1:0] dcode);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'h0, dcode, value, cmd};
        do @(posedge aclk); while (!s_tready);
        board.note_request(cmd, value, dcode);
        @(negedge aclk);
    endtask

    task automatic send_random_request();
        cmd_t        cmd;
        logic [15:0] value;
        int          pick;
        cmd  = cmd_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 7);
        if (pick == 0)
            value = 16'h0000;
        else if (pick == 1)
            value = 16'hFFFF;
        else if (pick == 2)
            value = 16'($urandom_range(0, 99));
        else
            value = 16'($urandom);
        send_request(cmd, value, 2'($urandom_range(0, 3)));
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending_pulses.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(int idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(4 * idx);
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, data);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_readback(int idx);
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 5'(4 * idx);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got !== board.reg_value(idx))
            board.report($sformatf("register %0d reads %h, expected %h",
                                   idx, got, board.reg_value(idx)));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(logic [7:0] nh, logic [7:0] nl, logic [7:0] wh,
                             logic [7:0] wl, logic [2:0] waits);
        cfg_write(REG_NIBBLE_HIGH, {24'($urandom), nh});
        cfg_write(REG_NIBBLE_LOW, {24'($urandom), nl});
        cfg_write(REG_WAIT_HIGH, {24'($urandom), wh});
        cfg_write(REG_WAIT_LOW, {24'($urandom), wl});
        cfg_write(REG_WAITS, {29'($urandom), waits});
        cfg_write($urandom_range(REG_WAITS + 1, 7), $urandom);
        for (int i = REG_NIBBLE_HIGH; i <= REG_WAITS; i++) begin
            cfg_readback(i);
        end
    endtask

    initial begin
        logic [2:0] waits;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (4) @(negedge aclk);

        for (int i = REG_NIBBLE_HIGH; i <= REG_WAITS; i++) begin
            cfg_readback(i);
        end
        send_request(CMD_INIT, 16'h0000, 2'd0);
        send_request(CMD_INSTR, 16'h0000, 2'd0);
        send_request(CMD_INSTR, 16'h00FF, 2'd3);
        send_request(CMD_INSTR, 16'h0002, 2'd0);
        send_request(CMD_INSTR, 16'hA55A, 2'd1);
        send_request(CMD_CHAR, 16'h0000, 2'd0);
        send_request(CMD_CHAR, 16'hFFFF, 2'd3);
        send_request(CMD_CHAR, 16'h7F41, 2'd2);
        send_request(CMD_NUM, 16'd0, 2'd0);
        send_request(CMD_NUM, 16'd0, 2'd3);
        send_request(CMD_NUM, 16'hFFFF, 2'd0);
        send_request(CMD_NUM, 16'hFFFF, 2'd1);
        send_request(CMD_NUM, 16'hFFFF, 2'd2);
        send_request(CMD_NUM, 16'hFFFF, 2'd3);
        send_request(CMD_NUM, 16'd12345, 2'd2);
        send_request(CMD_NUM, 16'd9999, 2'd3);
        send_request(CMD_NUM, 16'd10000, 2'd3);
        send_request(CMD_NUM, 16'd7, 2'd1);
        send_request(CMD_NUM, 16'd90, 2'd0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: configure(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
                1: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, WAITS_MAX);
                2: configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd7);
                default: begin
                    waits = 3'($urandom_range(0, 7));
                    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), waits);
                end
            endcase
            if (phase == RANDOM_PHASES - 1)
                no_idle = 1'b1;
            if (phase < 3) begin
                send_request(CMD_INIT, 16'($urandom), 2'($urandom_range(0, 3)));
                send_request(CMD_INSTR, 16'h0002, 2'd0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_request();
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending_pulses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
